// ===== rtl/dmn_pkg.sv =====
// ----------------------------------------------------------------------------
// dmn_pkg
// Shared widths, codes and controller/datapath interface types for the
// distributed mutual exclusion node.
// ----------------------------------------------------------------------------
`default_nettype none

package dmn_pkg;

    localparam int CLK_W      = 32;
    localparam int RANK_W     = 4;
    localparam int CNT_W      = 5;
    localparam int FUNC_W     = 2;
    localparam int KIND_W     = 2;
    localparam int PHASE_W    = 2;
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 5;

    // Default node limit and the hard ceiling that the 4-bit node field allows.
    localparam int NODES_DEF  = 16;
    localparam int MAX_LIVE   = 16;

    localparam logic [FUNC_W-1:0] FUNC_TOGGLE = 2'd0;
    localparam logic [FUNC_W-1:0] FUNC_REQ    = 2'd1;
    localparam logic [FUNC_W-1:0] FUNC_AGREE  = 2'd2;

    localparam logic [KIND_W-1:0] KIND_REQ    = 2'd0;
    localparam logic [KIND_W-1:0] KIND_AGREE  = 2'd1;
    localparam logic [KIND_W-1:0] KIND_GRANT  = 2'd2;

    localparam logic [PHASE_W-1:0] PH_IDLE    = 2'd0;
    localparam logic [PHASE_W-1:0] PH_REQ     = 2'd1;
    localparam logic [PHASE_W-1:0] PH_IN      = 2'd2;

    localparam logic [CFG_IDX_W-1:0] CFG_OWN_RANK   = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_NODE_COUNT = 2'd1;

    typedef struct packed {
        logic load_in;   // capture the accepted input transaction
        logic upd_clk;   // Lamport clock update
        logic decide;    // protocol decision, loads the pending result list
        logic emit;      // move one pending result into the output register
    } t_dp_cmd;

    typedef struct packed {
        logic work_left; // results still pending for the current item
        logic out_free;  // output register can take a result this cycle
    } t_dp_stat;

endpackage

`default_nettype wire

// ===== rtl/dmn_ctrl.sv =====
// ----------------------------------------------------------------------------
// dmn_ctrl
// Sequencing state machine: accept, clock update, decision, result drain.
// ----------------------------------------------------------------------------
`default_nettype none

module dmn_ctrl
    import dmn_pkg::*;
(
    input  wire logic     i_clk,
    input  wire logic     i_rst_n,
    input  wire logic     i_valid,
    output logic          o_ready,
    input  wire t_dp_stat i_stat,
    output t_dp_cmd       o_cmd
);

    localparam logic [1:0] S_IDLE = 2'd0;
    localparam logic [1:0] S_UPD  = 2'd1;
    localparam logic [1:0] S_DEC  = 2'd2;
    localparam logic [1:0] S_EMIT = 2'd3;

    logic [1:0] r_state;
    logic [1:0] n_state;

    always_comb begin
        n_state = r_state;
        o_cmd   = '0;
        o_ready = 1'b0;
        case (r_state)
            S_IDLE: begin
                o_ready = 1'b1;
                if (i_valid) begin
                    o_cmd.load_in = 1'b1;
                    n_state       = S_UPD;
                end
            end
            S_UPD: begin
                o_cmd.upd_clk = 1'b1;
                n_state       = S_DEC;
            end
            S_DEC: begin
                o_cmd.decide = 1'b1;
                n_state      = S_EMIT;
            end
            S_EMIT: begin
                if (!i_stat.work_left) begin
                    n_state = S_IDLE;
                end else if (i_stat.out_free) begin
                    o_cmd.emit = 1'b1;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

endmodule

`default_nettype wire

// ===== rtl/dmn_dp.sv =====
// ----------------------------------------------------------------------------
// dmn_dp
// Datapath: configuration, Lamport clock, protocol state, pending result
// list and the output register.
// ----------------------------------------------------------------------------
`default_nettype none

module dmn_dp
    import dmn_pkg::*;
#(
    parameter int NODES = NODES_DEF
) (
    input  wire logic                  i_clk,
    input  wire logic                  i_rst_n,
    input  wire logic                  i_cfg_valid,
    input  wire logic [CFG_IDX_W-1:0]  i_cfg_index,
    input  wire logic [CFG_DATA_W-1:0] i_cfg_data,
    input  wire logic [FUNC_W-1:0]     i_func,
    input  wire logic [RANK_W-1:0]     i_source_node,
    input  wire logic [CLK_W-1:0]      i_msg_clock,
    input  wire t_dp_cmd               i_cmd,
    output t_dp_stat                   o_stat,
    output logic                       o_valid,
    input  wire logic                  i_ready,
    output logic [RANK_W-1:0]          o_dest_node,
    output logic [KIND_W-1:0]          o_msg_kind,
    output logic [CLK_W-1:0]           o_out_clock,
    output logic                       o_last
);

    localparam int LIVE_MAX = (NODES < MAX_LIVE) ? NODES : MAX_LIVE;
    localparam int IDX_W    = $clog2(LIVE_MAX);

    // Configuration.
    logic [RANK_W-1:0]  r_own_rank;
    logic [CNT_W-1:0]   r_node_count;

    // Captured input transaction.
    logic [FUNC_W-1:0]  r_func;
    logic [RANK_W-1:0]  r_src;
    logic [CLK_W-1:0]   r_mclk;

    // Protocol state.
    logic [CLK_W-1:0]   r_clock;
    logic [PHASE_W-1:0] r_phase;
    logic [CLK_W-1:0]   r_req_clock;
    logic [CNT_W-1:0]   r_agree;
    logic [LIVE_MAX-1:0] r_defer;

    // Pending results of the current item: one per mask bit, then a grant.
    logic [LIVE_MAX-1:0] r_pend;
    logic [KIND_W-1:0]  r_pend_kind;
    logic               r_grant_pend;

    // Output register.
    logic               r_out_valid;
    logic [RANK_W-1:0]  r_out_dest;
    logic [KIND_W-1:0]  r_out_kind;
    logic [CLK_W-1:0]   r_out_clock;
    logic               r_out_last;

    logic [CNT_W-1:0]   v_n;
    logic [CLK_W-1:0]   v_max;
    logic [CLK_W-1:0]   v_clock_next;
    logic [LIVE_MAX-1:0] v_enter_mask;
    logic [LIVE_MAX-1:0] v_src_mask;
    logic               v_src_ok;
    logic               v_defer;
    logic [CNT_W-1:0]   v_agree_next;
    logic [IDX_W-1:0]   v_idx;
    logic [LIVE_MAX-1:0] v_pend_clr;
    logic               v_out_free;

    // Effective node count: zero counts as one, large values saturate.
    always_comb begin
        if (r_node_count == '0) begin
            v_n = CNT_W'(1);
        end else if (r_node_count > CNT_W'(LIVE_MAX)) begin
            v_n = CNT_W'(LIVE_MAX);
        end else begin
            v_n = r_node_count;
        end
    end

    // Lamport update, holding at the all-ones value.
    always_comb begin
        v_max        = (r_mclk > r_clock) ? r_mclk : r_clock;
        v_clock_next = (v_max == '1) ? v_max : v_max + CLK_W'(1);
    end

    always_comb begin
        for (int j = 0; j < LIVE_MAX; j++) begin
            v_enter_mask[j] = (CNT_W'(j) < v_n) && (RANK_W'(j) != r_own_rank);
            v_src_mask[j]   = (RANK_W'(j) == r_src);
        end
        v_src_ok = (r_src != r_own_rank) && ({1'b0, r_src} < v_n);
        v_defer  = (r_phase == PH_IN) ||
                   ((r_phase == PH_REQ) &&
                    ((r_req_clock < r_mclk) ||
                     ((r_req_clock == r_mclk) && (r_own_rank < r_src))));
        v_agree_next = (r_agree == '1) ? r_agree : r_agree + CNT_W'(1);
    end

    // Lowest pending destination goes out first.
    always_comb begin
        v_idx = '0;
        for (int j = LIVE_MAX - 1; j >= 0; j--) begin
            if (r_pend[j]) begin
                v_idx = IDX_W'(j);
            end
        end
        v_pend_clr        = r_pend;
        v_pend_clr[v_idx] = 1'b0;
    end

    assign v_out_free       = !r_out_valid || i_ready;
    assign o_stat.out_free  = v_out_free;
    assign o_stat.work_left = (r_pend != '0) || r_grant_pend;

    always_ff @(posedge i_clk) begin
        if (i_cmd.load_in) begin
            r_func <= i_func;
            r_src  <= i_source_node;
            r_mclk <= i_msg_clock;
        end
        if (i_cmd.emit) begin
            r_out_clock <= r_clock;
            if (r_pend != '0) begin
                r_out_dest <= RANK_W'(v_idx);
                r_out_kind <= r_pend_kind;
                r_out_last <= (v_pend_clr == '0) && !r_grant_pend;
            end else begin
                r_out_dest <= r_own_rank;
                r_out_kind <= KIND_GRANT;
                r_out_last <= 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_own_rank   <= '0;
            r_node_count <= CNT_W'(1);
            r_clock      <= '0;
            r_phase      <= PH_IDLE;
            r_req_clock  <= '0;
            r_agree      <= '0;
            r_defer      <= '0;
            r_pend       <= '0;
            r_pend_kind  <= KIND_REQ;
            r_grant_pend <= 1'b0;
            r_out_valid  <= 1'b0;
        end else begin
            if (i_cfg_valid) begin
                if (i_cfg_index == CFG_OWN_RANK) begin
                    r_own_rank <= i_cfg_data[RANK_W-1:0];
                end else if (i_cfg_index == CFG_NODE_COUNT) begin
                    r_node_count <= i_cfg_data;
                end
            end

            if (i_cmd.upd_clk) begin
                r_clock <= v_clock_next;
            end

            if (i_cmd.decide) begin
                case (r_func)
                    FUNC_TOGGLE: begin
                        if (r_phase == PH_IDLE) begin
                            r_pend       <= v_enter_mask;
                            r_pend_kind  <= KIND_REQ;
                            r_req_clock  <= r_clock;
                            r_agree      <= '0;
                            // A lone node is granted at once.
                            if (v_n <= CNT_W'(1)) begin
                                r_grant_pend <= 1'b1;
                                r_phase      <= PH_IN;
                            end else begin
                                r_phase <= PH_REQ;
                            end
                        end else if (r_phase == PH_IN) begin
                            r_pend      <= r_defer;
                            r_pend_kind <= KIND_AGREE;
                            r_defer     <= '0;
                            r_phase     <= PH_IDLE;
                        end
                    end
                    FUNC_REQ: begin
                        if (v_src_ok) begin
                            if (v_defer) begin
                                r_defer <= r_defer | v_src_mask;
                            end else begin
                                r_pend      <= v_src_mask;
                                r_pend_kind <= KIND_AGREE;
                            end
                        end
                    end
                    FUNC_AGREE: begin
                        if ((r_phase == PH_REQ) && (r_mclk > r_req_clock)) begin
                            r_agree <= v_agree_next;
                            if (v_agree_next >= v_n - CNT_W'(1)) begin
                                r_grant_pend <= 1'b1;
                                r_phase      <= PH_IN;
                            end
                        end
                    end
                    default: begin
                    end
                endcase
            end

            if (i_cmd.emit) begin
                if (r_pend != '0) begin
                    r_pend <= v_pend_clr;
                end else begin
                    r_grant_pend <= 1'b0;
                end
            end

            if (i_cmd.emit) begin
                r_out_valid <= 1'b1;
            end else if (i_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    assign o_valid     = r_out_valid;
    assign o_dest_node = r_out_dest;
    assign o_msg_kind  = r_out_kind;
    assign o_out_clock = r_out_clock;
    assign o_last      = r_out_last;

endmodule

`default_nettype wire

// ===== rtl/distributed_mutex_node.sv =====
// ----------------------------------------------------------------------------
// distributed_mutex_node
// One node of Ricart-Agrawala mutual exclusion with a saturating Lamport clock.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel (i_valid/o_ready) carries a local enter/exit toggle, a peer
//   request or a peer agree. Output channel (o_valid/i_ready) carries the
//   messages to peers and the grant to the local user; o_last marks the final
//   result of an input transaction. The configuration channel
//   (i_cfg_valid/o_cfg_ready) sets own rank (index 0) and node count
//   (index 1); it is always ready and is meant to be written while idle.
//   Sequencing: one transaction is worked at a time. After acceptance the node
//   performs the clock update, then the decision, then moves one result per
//   cycle into the output register while the receiver is ready. An item
//   occupies the node until its pending result list has drained through the
//   single output register. A stalled receiver holds the output register and
//   pauses the drain; the next input is taken once the current item's results
//   are all registered.
//   Reset (synchronous, active low) clears the clock, the protocol state and
//   the configuration to rank 0 and a node count of 1.
// ----------------------------------------------------------------------------
`default_nettype none

module distributed_mutex_node
    import dmn_pkg::*;
#(
    parameter int NODES = NODES_DEF
) (
    input  wire logic                  i_clk,
    input  wire logic                  i_rst_n,
    input  wire logic                  i_cfg_valid,
    output logic                       o_cfg_ready,
    input  wire logic [CFG_IDX_W-1:0]  i_cfg_index,
    input  wire logic [CFG_DATA_W-1:0] i_cfg_data,
    input  wire logic                  i_valid,
    output logic                       o_ready,
    input  wire logic [FUNC_W-1:0]     i_func,
    input  wire logic [RANK_W-1:0]     i_source_node,
    input  wire logic [CLK_W-1:0]      i_msg_clock,
    output logic                       o_valid,
    input  wire logic                  i_ready,
    output logic [RANK_W-1:0]          o_dest_node,
    output logic [KIND_W-1:0]          o_msg_kind,
    output logic [CLK_W-1:0]           o_out_clock,
    output logic                       o_last
);

    t_dp_cmd  w_cmd;
    t_dp_stat w_stat;

    assign o_cfg_ready = 1'b1;

    dmn_ctrl u_ctrl (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (i_valid),
        .o_ready (o_ready),
        .i_stat  (w_stat),
        .o_cmd   (w_cmd)
    );

    dmn_dp #(
        .NODES (NODES)
    ) u_dp (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_valid   (i_cfg_valid),
        .i_cfg_index   (i_cfg_index),
        .i_cfg_data    (i_cfg_data),
        .i_func        (i_func),
        .i_source_node (i_source_node),
        .i_msg_clock   (i_msg_clock),
        .i_cmd         (w_cmd),
        .o_stat        (w_stat),
        .o_valid       (o_valid),
        .i_ready       (i_ready),
        .o_dest_node   (o_dest_node),
        .o_msg_kind    (o_msg_kind),
        .o_out_clock   (o_out_clock),
        .o_last        (o_last)
    );

    // The node only takes a new transaction once the previous one is drained.
    a_idle_no_work: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_ready |-> !w_stat.work_left)
        else $error("input ready while results are still pending");

    a_accept_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_valid && o_ready) |=> !o_ready)
        else $error("node stayed ready after accepting a transaction");

    // A grant is always the final result of its transaction.
    a_grant_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && (o_msg_kind == KIND_GRANT)) |-> o_last)
        else $error("grant result not marked last");

endmodule

`default_nettype wire
